@@ rtl/core/lcf_pkg.sv @@
// Shared types and codes for the linear/circular FIFO.
// Used by lcf_ctrl, linear_or_circular_fifo and the bench; depends on nothing.
`default_nettype none

package lcf_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_RETURNED = 3'd1,
    ST_WRAPPED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_END      = 3'd5
  } status_t;

  // Occupancy class after a step
  typedef enum logic [1:0] {
    OCC_EMPTY = 2'd0,
    OCC_PART  = 2'd1,
    OCC_FULL  = 2'd2
  } occ_t;

  // Item opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_MODE = 4'd1;

  // Register reset values
  localparam logic [4:0] CAP_RESET  = 5'd16;
  localparam logic       WRAP_RESET = 1'b1;

  // Decision of the control unit for one item
  typedef struct packed {
    logic    wr_en;     // store the data word
    logic    rd_en;     // read the oldest word
    status_t status;
    occ_t    occ;       // class after the step
  } lcf_access_t;

endpackage

`default_nettype wire

@@ rtl/core/lcf_mem.sv @@
// Storage array of the FIFO: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module lcf_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lcf_ctrl.sv @@
// Pointer, count and configuration registers of the FIFO, plus the per-item decision.
// Depends on lcf_pkg.
`default_nettype none

module lcf_ctrl #(
  parameter int unsigned MEM_DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [lcf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [lcf_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                  accept,
  input  wire logic                                  opcode,
  output lcf_pkg::lcf_access_t                       access,
  output logic      [$clog2(MEM_DEPTH)-1:0]          addr,
  output logic      [$clog2(MEM_DEPTH+1)-1:0]        count_after
);

  import lcf_pkg::*;

  localparam int unsigned AW    = $clog2(MEM_DEPTH);
  localparam int unsigned CNT_W = $clog2(MEM_DEPTH + 1);
  localparam logic [4:0]  CAP_MAX = 5'(MEM_DEPTH);

  logic [4:0]       capacity;
  logic             wrap_mode;
  logic [CNT_W-1:0] wr_pos, wr_pos_next;
  logic [CNT_W-1:0] rd_pos, rd_pos_next;
  logic [CNT_W-1:0] count, count_next;
  logic [4:0]       cap_clamp;
  logic [CNT_W-1:0] cap;

  // Clamp capacity into 1..MEM_DEPTH
  always_comb begin
    if (capacity == 5'd0) begin
      cap_clamp = 5'd1;
    end else if (capacity > CAP_MAX) begin
      cap_clamp = CAP_MAX;
    end else begin
      cap_clamp = capacity;
    end
    cap = cap_clamp[CNT_W-1:0];
  end

  always_comb begin
    wr_pos_next   = wr_pos;
    rd_pos_next   = rd_pos;
    count_next    = count;
    access.wr_en  = 1'b0;
    access.rd_en  = 1'b0;
    addr          = '0;
    if (opcode == OP_ENQ) begin
      if (count >= cap) begin
        access.status = ST_FULL;
      end else if (wr_pos >= cap) begin
        if (!wrap_mode) begin
          access.status = ST_END;
        end else begin
          access.status = ST_WRAPPED;
          access.wr_en  = 1'b1;
          wr_pos_next   = CNT_W'(1);
          count_next    = count + CNT_W'(1);
        end
      end else begin
        access.status = ST_ADDED;
        access.wr_en  = 1'b1;
        addr          = wr_pos[AW-1:0];
        wr_pos_next   = wr_pos + CNT_W'(1);
        count_next    = count + CNT_W'(1);
      end
    end else begin
      if (count == '0) begin
        access.status = ST_EMPTY;
      end else if (rd_pos >= cap) begin
        if (!wrap_mode) begin
          access.status = ST_END;
        end else begin
          access.status = ST_WRAPPED;
          access.rd_en  = 1'b1;
          rd_pos_next   = CNT_W'(1);
          count_next    = count - CNT_W'(1);
        end
      end else begin
        access.status = ST_RETURNED;
        access.rd_en  = 1'b1;
        addr          = rd_pos[AW-1:0];
        rd_pos_next   = rd_pos + CNT_W'(1);
        count_next    = count - CNT_W'(1);
      end
    end

    if (count_next >= cap) begin
      access.occ = OCC_FULL;
    end else if (count_next == '0) begin
      access.occ = OCC_EMPTY;
    end else begin
      access.occ = OCC_PART;
    end
    count_after = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      wrap_mode <= WRAP_RESET;
      wr_pos    <= '0;
      rd_pos    <= '0;
      count     <= '0;
    end else if (cfg_we && (cfg_index == CFG_CAPACITY || cfg_index == CFG_WRAP_MODE)) begin
      // Any register write restarts the queue; stored words stay
      if (cfg_index == CFG_CAPACITY) begin
        capacity <= cfg_data;
      end else begin
        wrap_mode <= cfg_data[0];
      end
      wr_pos <= '0;
      rd_pos <= '0;
      count  <= '0;
    end else if (accept) begin
      wr_pos <= wr_pos_next;
      rd_pos <= rd_pos_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/linear_or_circular_fifo.sv @@
// Linear/circular FIFO top level: control unit, storage array, two result stages.
// An item's result is registered in the decision stage, then in the output register;
// one item per cycle sustained while the result side keeps taking results.
// Two result stages absorb output stalls.
// Reset (synchronous, rst high): positions and count cleared, capacity 16, circular mode;
// stored words are not cleared and need no clearing pass. Depends on lcf_pkg, lcf_ctrl, lcf_mem.
`default_nettype none

module linear_or_circular_fifo #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // item channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              opcode,
  input  wire logic [31:0]                       data_in,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [2:0]                        status,
  output logic      [31:0]                       data_out,
  output logic      [1:0]                        occupancy,
  output logic      [4:0]                        fill_count,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lcf_pkg::*;

  // Capacity is a 5-bit register, so no more than 31 entries are ever addressed.
  localparam int unsigned MEM_DEPTH = (DEPTH < 31) ? DEPTH : 31;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned CNT_W     = $clog2(MEM_DEPTH + 1);

  lcf_access_t           access;
  logic [AW-1:0]         addr;
  logic [CNT_W-1:0]      count_after;
  logic                  accept;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [31:0]           rd_word;

  // Decision stage: holds the item's result while its read data settles
  logic                  s1_valid;
  logic                  s1_has_data;
  status_t               s1_status;
  occ_t                  s1_occ;
  logic [CNT_W-1:0]      s1_count;
  logic                  s1_advance;

  // Configuration writes are always taken; the user must send them only while the FIFO is idle.
  assign cfg_ready = 1'b1;

  // Advance the decision stage when the output register is free or being drained;
  // take a new item when the decision stage is empty or empties in the same cycle.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  // Fit the 32-bit port to the stored word width: truncate or zero-extend.
  generate
    if (DATA_WIDTH <= 32) begin : g_narrow
      assign wr_data = data_in[DATA_WIDTH-1:0];
      assign rd_word = 32'(rd_data);
    end else begin : g_wide
      assign wr_data = DATA_WIDTH'(data_in);
      assign rd_word = rd_data[31:0];
    end
  endgenerate

  lcf_ctrl #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .opcode      (opcode),
    .access      (access),
    .addr        (addr),
    .count_after (count_after)
  );

  // The read register only changes on a dequeue transfer, and a transfer happens only when
  // the decision stage is empty or hands its item on in the same edge, so its data stays put.
  lcf_mem #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && access.wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (accept && access.rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Decision stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Decision stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_has_data <= access.rd_en;
      s1_status   <= access.status;
      s1_occ      <= access.occ;
      s1_count    <= count_after;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; drop the read word unless a dequeue succeeded
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      status     <= s1_status;
      data_out   <= s1_has_data ? rd_word : 32'd0;
      occupancy  <= s1_occ;
      fill_count <= 5'(s1_count);
    end
  end

endmodule

`default_nettype wire

@@ tb/lcf_result_checker.sv @@
// Result checker for the linear/circular FIFO: mirrors positions, count and stored words,
// predicts one result per item transfer and compares it with each result transfer.
// Depends on lcf_pkg for the status, occupancy, opcode and register codes.

module lcf_result_checker
  import lcf_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   opcode,
  input  logic [31:0]            data_in,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [2:0]             status,
  input  logic [31:0]            data_out,
  input  logic [1:0]             occupancy,
  input  logic [4:0]             fill_count,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t     status;
    logic [31:0] word;
    occ_t        occ;
    logic [4:0]  count;
  } fifo_result_t;

  fifo_result_t awaited_results[$];
  logic [31:0]  mirror[DEPTH];
  int unsigned  wr_ptr, rd_ptr, held;
  logic [4:0]   cap_reg;
  logic         wrap_reg;
  int           errors;

  // Out-of-range capacity values clamp into 1..DEPTH.
  function automatic int unsigned usable_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  // Apply one access to the mirror and return the result it must produce.
  // Full/empty win over the end-of-buffer check; the wrap happens lazily.
  function automatic fifo_result_t fifo_access(input logic op, input logic [31:0] word);
    fifo_result_t r;
    int unsigned  lim;
    lim = usable_capacity();
    r.word = '0;
    if (op == OP_ENQ) begin
      if (held >= lim) begin
        r.status = ST_FULL;
      end else if (wr_ptr >= lim) begin
        if (!wrap_reg) begin
          r.status = ST_END;
        end else begin
          mirror[0] = word;
          wr_ptr = 1;
          held++;
          r.status = ST_WRAPPED;
        end
      end else begin
        mirror[wr_ptr] = word;
        wr_ptr++;
        held++;
        r.status = ST_ADDED;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else if (rd_ptr >= lim) begin
        if (!wrap_reg) begin
          r.status = ST_END;
        end else begin
          r.word = mirror[0];
          rd_ptr = 1;
          held--;
          r.status = ST_WRAPPED;
        end
      end else begin
        r.word = mirror[rd_ptr];
        rd_ptr++;
        held--;
        r.status = ST_RETURNED;
      end
    end
    r.occ   = (held >= lim) ? OCC_FULL : ((held == 0) ? OCC_EMPTY : OCC_PART);
    r.count = held[4:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    fifo_result_t want;
    if (rst) begin
      wr_ptr   = 0;
      rd_ptr   = 0;
      held     = 0;
      cap_reg  = CAP_RESET;
      wrap_reg = WRAP_RESET;
      awaited_results.delete();
    end else begin
      // Retire the oldest expectation before adding the one from this edge.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $error("unexpected result transfer: status %0d data_out %h", status, data_out);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", want.status, status);
          end
          if (data_out !== want.word) begin
            errors++;
            $error("data_out: expected %h, actual %h", want.word, data_out);
          end
          if (occupancy !== want.occ) begin
            errors++;
            $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
          end
          if (fill_count !== want.count) begin
            errors++;
            $error("fill_count: expected %0d, actual %0d", want.count, fill_count);
          end
        end
      end
      // Either register clears positions and count; stored words stay.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY: begin
            cap_reg = cfg_data;
            wr_ptr  = 0;
            rd_ptr  = 0;
            held    = 0;
          end
          CFG_WRAP_MODE: begin
            wrap_reg = cfg_data[0];
            wr_ptr   = 0;
            rd_ptr   = 0;
            held     = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) awaited_results.push_back(fifo_access(opcode, data_in));
    end
    fail_count <= errors;
    pending    <= awaited_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the linear/circular FIFO bench: clock, reset, item and configuration stimulus,
// result-side back-pressure and the verdict. Depends on lcf_pkg, the block and
// lcf_result_checker, which does all prediction and comparison.

module tb_top;
  import lcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned STEADY_ITEMS = 60;      // tail of the run without idling
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;       // lets the two result stages empty
  localparam int unsigned HOLD_CYCLES  = 60;      // long result-side hold-off
  // An index past the register list: the block must ignore it.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 4'd15;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   opcode;
  logic [31:0]            data_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [2:0]             status;
  logic [31:0]            data_out;
  logic [1:0]             occupancy;
  logic [4:0]             fill_count;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int                     fail_count;
  int                     pending;
  int unsigned            cycles;
  logic                   steady;    // set for the tail: no idling on either side
  logic                   squeeze;   // asks the result side for its long hold-off

  linear_or_circular_fifo dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .data_in    (data_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data_out   (data_out),
    .occupancy  (occupancy),
    .fill_count (fill_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lcf_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .data_in    (data_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .data_out   (data_out),
    .occupancy  (occupancy),
    .fill_count (fill_count),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one item and hold it, payload unchanged, until the transfer.
  // Valid is not dropped here, so back-to-back items keep it high.
  task automatic push_item(input logic op, input logic [31:0] word);
    in_valid <= 1'b1;
    opcode   <= op;
    data_in  <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_input(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hold cfg_valid across consecutive writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram only once the block is idle. The wrap write carries random upper
  // bits, which the block must ignore; a stray write to an unused index may follow.
  task automatic configure(input logic [4:0] cap, input logic mode, input logic stray);
    settle();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_WRAP_MODE, {4'($urandom), mode});
    if (stray) write_reg(CFG_UNMAPPED, 5'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall bursts, one long hold-off on request, none in the tail.
  initial begin : sink
    bit squeezed;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned run;
    int unsigned bias;
    bit          quiet;
    bit          calm;
    logic [4:0]  cap_pick;
    logic        op;
    logic [31:0] word;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= OP_ENQ;
    data_in   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= '0;
    steady    <= 1'b0;
    squeeze   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (16 entries, circular): empty, extreme words, plain returns.
    push_item(OP_DEQ, $urandom);            // empty
    push_item(OP_ENQ, 32'h0000_0000);
    push_item(OP_ENQ, 32'hFFFF_FFFF);
    push_item(OP_DEQ, $urandom);
    push_item(OP_DEQ, $urandom);

    // Two entries, linear: full, then stuck at the end until reprogrammed.
    configure(5'd2, 1'b0, 1'b0);
    push_item(OP_ENQ, 32'hA5A5_A5A5);
    push_item(OP_ENQ, 32'h5A5A_5A5A);
    push_item(OP_ENQ, $urandom);            // full
    push_item(OP_DEQ, $urandom);
    push_item(OP_ENQ, $urandom);            // reached end
    push_item(OP_DEQ, $urandom);
    push_item(OP_DEQ, $urandom);            // empty
    push_item(OP_ENQ, $urandom);            // reached end

    // Capacity zero acts as one; circular mode wraps both positions.
    // The stray write to an unused index must not clear anything.
    configure(5'd0, 1'b1, 1'b1);
    push_item(OP_ENQ, $urandom);
    push_item(OP_ENQ, $urandom);            // full
    push_item(OP_DEQ, $urandom);
    push_item(OP_ENQ, $urandom);            // write wraps
    push_item(OP_DEQ, $urandom);            // read wraps
    push_item(OP_DEQ, $urandom);            // empty

    // Capacity above the storage depth clamps to the depth.
    configure(5'd31, 1'b1, 1'b0);
    push_item(OP_ENQ, $urandom);
    push_item(OP_DEQ, $urandom);

    // Random phases: each picks settings, then alternates fill-leaning and
    // drain-leaning runs so full, empty, wrap and end all come up often.
    sent = 0;
    run  = 0;
    bias = 80;
    calm = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       cap_pick = 5'd0;
        1:       cap_pick = 5'd1;
        2:       cap_pick = 5'd2;
        3:       cap_pick = 5'($urandom_range(3, 15));
        4:       cap_pick = 5'd16;
        default: cap_pick = 5'($urandom_range(17, 31));
      endcase
      // Keep the tail free of the idle gap a reprogram needs.
      if (!calm) configure(cap_pick, $urandom_range(0, 9) < 6, $urandom_range(0, 3) == 0);
      // First phase: the result side stalls long while items keep coming.
      if (sent == 0) squeeze <= 1'b1;
      phase_len = $urandom_range(20, 80);
      quiet     = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        if (run == 0) begin
          run  = $urandom_range(1, 20);
          bias = (bias > 50) ? 20 : 80;
        end
        run--;
        op   = ($urandom_range(0, 99) < bias) ? OP_ENQ : OP_DEQ;
        word = ($urandom_range(0, 7) == 0) ? {32{$urandom_range(0, 1) == 1}} : $urandom;
        if (!calm && sent >= RANDOM_ITEMS - STEADY_ITEMS) begin
          calm = 1'b1;
          steady <= 1'b1;
        end
        if (!quiet && !calm && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 19));
        push_item(op, word);
        sent++;
      end
    end

    // Wait out every result, then give the verdict.
    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
